>>> design/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg: shared definitions for the PID power controller
// Widths, register indexes, clamp codes, reset values and the types that
// travel between the controller's modules.
// ----------------------------------------------------------------------------
package ppc_pkg;

   // error history window
   localparam int WINDOW_LEN = 16;

   // field widths
   localparam int TEMP_W = 10;
   localparam int GAIN_W = 16;
   localparam int MW_W   = 17;
   localparam int ERR_W  = 11;
   localparam int SUM_W  = 15;
   localparam int DIFF_W = 12;
   localparam int CODE_W = 2;

   // scaler datapath: term * gain, then divide by 100 as >>2 and *recip(25)
   localparam int TERM_W      = 15;
   localparam int PROD_W      = 34;
   localparam int MAG_W       = 28;
   localparam int RECIP_W     = 29;
   localparam int RECIP_SHIFT = 33;
   localparam int RP_W        = MAG_W + RECIP_W;
   localparam int QUOT_W      = RP_W - RECIP_SHIFT + 1;
   localparam int DRIVE_W     = QUOT_W + 2;
   localparam logic [RECIP_W-1:0] RECIP_MUL = 29'd343597384;  // ceil(2^33 / 25)

   // drive limits in milliwatts
   localparam int DRIVE_FLOOR = 1000;
   localparam int DRIVE_CEIL  = 100000;

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

   // stream widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = MW_W;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_TEMP = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KP          = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_KI          = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_KD          = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_MW      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_INIT_MW     = 3'd5;

   localparam logic [TEMP_W-1:0] TARGET_RESET  = 10'd200;
   localparam logic [GAIN_W-1:0] GAIN_RESET    = 16'd0;
   localparam logic [MW_W-1:0]   MAX_MW_RESET  = 17'd75000;
   localparam logic [MW_W-1:0]   INIT_MW_RESET = 17'd20000;

   // operation codes carried in tuser
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef enum logic [CODE_W-1:0] {
      CLAMP_NONE,
      CLAMP_NEGATIVE,
      CLAMP_RUNAWAY,
      CLAMP_LIMIT
   } ppc_clamp_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } ppc_cell_ctrl_type;

   // first member sits in the highest bits
   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic signed [ERR_W-1:0] err;
      ppc_clamp_type           code;
      logic [MW_W-1:0]         drive;
   } ppc_result_type;

   localparam int RESULT_W = $bits(ppc_result_type);

endpackage

>>> design/pid_power_controller.sv
// ----------------------------------------------------------------------------
// pid_power_controller: temperature-to-power PID with windowed integral
// Path: a transaction accepted on the request stream passes the side register,
//   three scaler stages, one sum stage and a queue write before rsp_tvalid.
// Throughput: one transaction per cycle while req_tready is high; error-sum
//   loop closes in a single add per cycle; up to eight in flight under stall.
// Reset: synchronous, clears the history cells, sum, previous error, pipeline
//   valid bits and result queue, and loads the default register values.
// ----------------------------------------------------------------------------
module pid_power_controller (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ppc_pkg::REQ_DATA_W-1:0]    req_tdata,   // [9:0] measured_temp
   input  logic                              req_tuser,   // [0] operation
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [16:0] drive_milliwatts, [18:17] clamp_code, [29:19] temp_error,
   // [44:30] window_sum
   output logic [ppc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register write port
   input  logic                              csr_we,
   input  logic [ppc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [ppc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ppc_pkg::*;

   localparam int STAGES   = 5;
   localparam int SCALED_AT = 3;  // stage index where scaler outputs line up

   typedef struct packed {
      logic                    clear;
      logic signed [ERR_W-1:0] err;
      logic signed [SUM_W-1:0] sum;
   } ppc_side_type;

   // ---------------------------------------------------------------- registers
   logic [TEMP_W-1:0] target_ff;
   logic [GAIN_W-1:0] kp_ff;
   logic [GAIN_W-1:0] ki_ff;
   logic [GAIN_W-1:0] kd_ff;
   logic [MW_W-1:0]   max_mw_ff;
   logic [MW_W-1:0]   init_mw_ff;

   // Writes to unused indexes drop silently.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= TARGET_RESET;
         kp_ff      <= GAIN_RESET;
         ki_ff      <= GAIN_RESET;
         kd_ff      <= GAIN_RESET;
         max_mw_ff  <= MAX_MW_RESET;
         init_mw_ff <= INIT_MW_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TARGET_TEMP: target_ff  <= csr_wdata[TEMP_W-1:0];
            CSR_KP:          kp_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_KI:          ki_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_KD:          kd_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_MAX_MW:      max_mw_ff  <= csr_wdata[MW_W-1:0];
            CSR_INIT_MW:     init_mw_ff <= csr_wdata[MW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------- handshakes
   logic                req_fire;
   logic                rsp_fire;
   logic                op;
   logic [TEMP_W-1:0]   meas;
   logic [CREDIT_W-1:0] credit_ff;
   logic [CREDIT_W-1:0] credit_in;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;
   assign op       = req_tuser;
   assign meas     = req_tdata[TEMP_W-1:0];

   // Count transactions accepted but not yet delivered; the queue is deep
   // enough for everything in flight, so stop accepting only when the count
   // reaches its depth.
   assign req_tready = (credit_ff != CREDIT_W'(FIFO_DEPTH));
   assign credit_in  = credit_ff + CREDIT_W'(req_fire) - CREDIT_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   // ------------------------------------------------------ error and history
   logic signed [ERR_W-1:0]  err_c;
   logic signed [SUM_W-1:0]  sum_c;
   logic signed [DIFF_W-1:0] diff_c;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [ERR_W-1:0]  prev_ff;
   logic signed [ERR_W-1:0]  chain [WINDOW_LEN+1];
   ppc_cell_ctrl_type        cell_ctrl;

   assign err_c = $signed(ERR_W'(target_ff)) - $signed(ERR_W'(meas));

   // The last cell holds the error that leaves the window on this sample.
   assign sum_c  = sum_ff + SUM_W'(err_c) - SUM_W'(chain[WINDOW_LEN]);
   assign diff_c = DIFF_W'(prev_ff) - DIFF_W'(err_c);

   assign cell_ctrl.shift = req_fire & (op == OP_SAMPLE);
   assign cell_ctrl.clear = req_fire & (op == OP_CLEAR);

   assign chain[0] = err_c;

   for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
      ppc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .shift_in (chain[i]),
         .value    (chain[i+1])
      );
   end

   // Clear empties the window but keeps the previous error.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         prev_ff <= '0;
      end else if (cell_ctrl.clear) begin
         sum_ff  <= '0;
      end else if (cell_ctrl.shift) begin
         sum_ff  <= sum_c;
         prev_ff <= err_c;
      end
   end

   // --------------------------------------------------------------- pipeline
   logic [STAGES-1:0]        valid_ff;
   ppc_side_type             side_ff [STAGES];
   ppc_side_type             side_in;
   logic signed [DIFF_W-1:0] diff_ff;

   assign side_in.clear = op;
   assign side_in.err   = (op == OP_CLEAR) ? '0 : err_c;
   assign side_in.sum   = (op == OP_CLEAR) ? '0 : sum_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STAGES-2:0], req_fire};
      end
   end

   // Advance every cycle; valid bits mark which stages carry a transaction.
   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      diff_ff    <= (op == OP_CLEAR) ? '0 : diff_c;
      for (int s = 1; s < STAGES; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   // Three gain terms, each divided by 100 separately as the control law does.
   logic signed [QUOT_W-1:0] q_err;
   logic signed [QUOT_W-1:0] q_sum;
   logic signed [QUOT_W-1:0] q_diff;

   ppc_scaler u_scale_p (
      .clock (clock),
      .term  (TERM_W'(side_ff[0].err)),
      .gain  (kp_ff),
      .quot  (q_err)
   );

   ppc_scaler u_scale_i (
      .clock (clock),
      .term  (side_ff[0].sum),
      .gain  (ki_ff),
      .quot  (q_sum)
   );

   ppc_scaler u_scale_d (
      .clock (clock),
      .term  (TERM_W'(diff_ff)),
      .gain  (kd_ff),
      .quot  (q_diff)
   );

   // Sum stage lines up with the last side stage.
   logic signed [DRIVE_W-1:0] drive_ff;

   always_ff @(posedge clock) begin
      if (valid_ff[SCALED_AT]) begin
         drive_ff <= DRIVE_W'(q_err) + DRIVE_W'(q_sum) + DRIVE_W'(q_diff);
      end
   end

   // ------------------------------------------------------------------ clamp
   // Order matters: negative and runaway fall back to the floor first, then
   // the user limit may override either.
   logic signed [DRIVE_W-1:0] drive_lim;
   ppc_clamp_type             code_lim;
   ppc_result_type            result;

   always_comb begin
      drive_lim = drive_ff;
      code_lim  = CLAMP_NONE;
      if (drive_ff < 0) begin
         drive_lim = DRIVE_W'(DRIVE_FLOOR);
         code_lim  = CLAMP_NEGATIVE;
      end
      if (drive_lim > $signed(DRIVE_W'(DRIVE_CEIL))) begin
         drive_lim = DRIVE_W'(DRIVE_FLOOR);
         code_lim  = CLAMP_RUNAWAY;
      end
      if (drive_lim > $signed(DRIVE_W'(max_mw_ff))) begin
         drive_lim = $signed(DRIVE_W'(max_mw_ff));
         code_lim  = CLAMP_LIMIT;
      end
   end

   always_comb begin
      result.sum = side_ff[STAGES-1].sum;
      result.err = side_ff[STAGES-1].err;
      if (side_ff[STAGES-1].clear) begin
         // clear reports the start-up power unclamped
         result.drive = init_mw_ff;
         result.code  = CLAMP_NONE;
      end else begin
         result.drive = drive_lim[MW_W-1:0];
         result.code  = code_lim;
      end
   end

   // ------------------------------------------------------------ result queue
   ppc_result_type rsp_data;

   ppc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (valid_ff[STAGES-1]),
      .wr_data  (result),
      .rd_en    (rsp_fire),
      .rd_valid (rsp_tvalid),
      .rd_data  (rsp_data)
   );

   assign rsp_tdata = {(RSP_DATA_W-RESULT_W)'(0), rsp_data};

endmodule

>>> design/ppc_cell.sv
// ----------------------------------------------------------------------------
// ppc_cell: one slot of the error history chain
// Holds one error; loads its neighbor's value on shift, zeroes on clear.
// ----------------------------------------------------------------------------
module ppc_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ppc_pkg::ppc_cell_ctrl_type           ctrl,
   input  logic signed [ppc_pkg::ERR_W-1:0]     shift_in,
   output logic signed [ppc_pkg::ERR_W-1:0]     value
);
   import ppc_pkg::*;

   logic signed [ERR_W-1:0] value_ff;
   logic signed [ERR_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.clear) begin
         value_in = '0;
      end else if (ctrl.shift) begin
         value_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

>>> design/ppc_scaler.sv
// ----------------------------------------------------------------------------
// ppc_scaler: gain term, three-stage pipeline
// Computes term * gain / 100 truncated toward zero: multiply, then divide
// the magnitude by 4 (shift) and by 25 (reciprocal multiply), then resign.
// ----------------------------------------------------------------------------
module ppc_scaler (
   input  logic                                  clock,
   input  logic signed [ppc_pkg::TERM_W-1:0]     term,
   input  logic [ppc_pkg::GAIN_W-1:0]            gain,
   output logic signed [ppc_pkg::QUOT_W-1:0]     quot
);
   import ppc_pkg::*;

   logic signed [GAIN_W:0]   term_ext;
   logic signed [GAIN_W:0]   gain_ext;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;

   logic                     neg_in;
   logic [PROD_W-1:0]        mag;
   logic [RP_W-1:0]          rp_in;
   logic [RP_W-1:0]          rp_ff;
   logic                     neg_ff;

   logic [QUOT_W-2:0]        q_mag;
   logic signed [QUOT_W-1:0] quot_in;
   logic signed [QUOT_W-1:0] quot_ff;

   // stage A: signed product
   assign term_ext = (GAIN_W+1)'(term);
   assign gain_ext = $signed({1'b0, gain});
   assign prod_in  = term_ext * gain_ext;

   // stage B: |prod| / 4 times reciprocal of 25
   assign neg_in = prod_ff[PROD_W-1];
   assign mag    = neg_in ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign rp_in  = RP_W'(mag[MAG_W+1:2]) * RP_W'(RECIP_MUL);

   // stage C: drop fraction, restore sign
   assign q_mag   = rp_ff[RP_W-1:RECIP_SHIFT];
   assign quot_in = neg_ff ? (QUOT_W'(0) - $signed({1'b0, q_mag})) : $signed({1'b0, q_mag});

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rp_ff   <= rp_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

>>> design/ppc_fifo.sv
// ----------------------------------------------------------------------------
// ppc_fifo: result queue
// Small register queue between the pipeline and the result stream.
// ----------------------------------------------------------------------------
module ppc_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  ppc_pkg::ppc_result_type wr_data,
   input  logic                    rd_en,
   output logic                    rd_valid,
   output ppc_pkg::ppc_result_type rd_data
);
   import ppc_pkg::*;

   ppc_result_type     entry_ff [FIFO_DEPTH];
   logic [FIFO_AW:0]   wr_ptr_ff;
   logic [FIFO_AW:0]   wr_ptr_in;
   logic [FIFO_AW:0]   rd_ptr_ff;
   logic [FIFO_AW:0]   rd_ptr_in;

   assign wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff[FIFO_AW-1:0]] <= wr_data;
      end
   end

   assign rd_valid = (wr_ptr_ff != rd_ptr_ff);
   assign rd_data  = entry_ff[rd_ptr_ff[FIFO_AW-1:0]];

endmodule

>>> design/ppc_checker.sv
// ----------------------------------------------------------------------------
// ppc_checker: port-level checks for the PID power controller
// Watches the streams and flags stalls, fallback values and queue misuse.
// ----------------------------------------------------------------------------
module ppc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ppc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import ppc_pkg::*;

   logic [MW_W-1:0]   drive;
   logic [CODE_W-1:0] code;

   assign drive = rsp_tdata[MW_W-1:0];
   assign code  = rsp_tdata[MW_W+CODE_W-1:MW_W];

   // a stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // nothing left over from before reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // input stops only when results wait at the output
   a_full_pending: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input blocked with no result pending");

   // both fallbacks drive the floor value
   a_fallback: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (code == CLAMP_NEGATIVE || code == CLAMP_RUNAWAY)
      |-> drive == MW_W'(DRIVE_FLOOR))
      else $error("fallback drive is not the floor value");

   // a limited drive sits below the runaway bound
   a_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && code == CLAMP_LIMIT |-> drive < MW_W'(DRIVE_CEIL))
      else $error("limited drive above runaway bound");

endmodule

bind pid_power_controller ppc_checker u_ppc_checker (.*);

>>> test/pid_power_controller_tb.sv
// ----------------------------------------------------------------------------
// pid_power_controller_tb: self-checking bench for the PID power controller
// Streams temperature samples and history clears into the controller, keeps
// a behavioral copy of the error window and gains to predict every drive
// command, and checks each result field in order. Registers are reprogrammed
// between phases while the controller is idle. Both stream sides idle at
// random, and one long receiver stall backs the result queue up into the input.
// ----------------------------------------------------------------------------
module pid_power_controller_tb;
   import ppc_pkg::*;

   localparam int CLOCK_HALF     = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int STALL_AT       = 400;    // result count that triggers the long stall
   localparam int STALL_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 4000;   // cycles without any transaction
   localparam int DRAIN_CYCLES   = 12;     // settling time after the last command returns
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 140;

   // addresses past the last register; writes there must change nothing
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      logic              op;
      logic [TEMP_W-1:0] temp;
   } sample_item_type;

   // DUT ports, all inputs at known values from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [9:0] measured_temp
   logic                  req_tuser  = OP_SAMPLE;   // [0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [16:0] drive_milliwatts, [18:17] clamp_code, [29:19] temp_error,
   // [44:30] window_sum
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // shadow registers, loaded with the reset values
   logic [TEMP_W-1:0] cfg_target  = TARGET_RESET;
   logic [GAIN_W-1:0] cfg_kp      = GAIN_RESET;
   logic [GAIN_W-1:0] cfg_ki      = GAIN_RESET;
   logic [GAIN_W-1:0] cfg_kd      = GAIN_RESET;
   logic [MW_W-1:0]   cfg_max_mw  = MAX_MW_RESET;
   logic [MW_W-1:0]   cfg_init_mw = INIT_MW_RESET;

   // shadow controller state
   logic signed [ERR_W-1:0] err_ring [WINDOW_LEN];
   int                      ring_slot = 0;
   logic signed [SUM_W-1:0] err_sum   = '0;
   logic signed [ERR_W-1:0] last_err  = '0;

   sample_item_type pending_samples[$];
   ppc_result_type  predicted_commands[$];
   sample_item_type item_on_bus;
   ppc_result_type  seen_cmd;
   ppc_result_type  want_cmd;

   int req_wait     = 0;
   int rsp_wait     = 0;
   int req_gap_max  = 0;
   int rsp_gap_max  = 0;
   int results_seen = 0;
   int mismatches   = 0;
   int quiet_cycles = 0;

   pid_power_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #CLOCK_HALF clock = ~clock;

   // Advance the shadow state by one transaction and return the command the
   // controller should produce for it.
   function automatic ppc_result_type predict_command(sample_item_type item);
      ppc_result_type          cmd;
      ppc_clamp_type           code;
      logic signed [ERR_W-1:0] err;
      longint                  diff;
      longint                  drive;
      cmd = '0;
      if (item.op == OP_CLEAR) begin
         // empty the window; the previous error survives a clear
         foreach (err_ring[i]) err_ring[i] = '0;
         ring_slot = 0;
         err_sum   = '0;
         cmd.drive = cfg_init_mw;
         return cmd;
      end
      err = ERR_W'(int'(cfg_target) - int'(item.temp));
      // drop the oldest error (the slot being overwritten), add the new one
      err_sum = err_sum + err - err_ring[ring_slot];
      err_ring[ring_slot] = err;
      ring_slot = (ring_slot + 1) % WINDOW_LEN;
      diff = longint'(last_err) - longint'(err);
      last_err = err;
      // each term divides on its own, truncating toward zero
      drive = longint'(err) * longint'(cfg_kp) / 100
            + longint'(err_sum) * longint'(cfg_ki) / 100
            + diff * longint'(cfg_kd) / 100;
      code = CLAMP_NONE;
      if (drive < 0) begin
         drive = DRIVE_FLOOR;
         code  = CLAMP_NEGATIVE;
      end
      if (drive > DRIVE_CEIL) begin
         drive = DRIVE_FLOOR;
         code  = CLAMP_RUNAWAY;
      end
      // the power limit wins over either fallback
      if (drive > longint'(cfg_max_mw)) begin
         drive = cfg_max_mw;
         code  = CLAMP_LIMIT;
      end
      cmd.drive = MW_W'(drive);
      cmd.code  = code;
      cmd.err   = err;
      cmd.sum   = err_sum;
      return cmd;
   endfunction

   task automatic check_field(string label, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   // Driver: present pending samples, predict each one on acceptance, then
   // hold off for a random number of cycles before the next.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_commands.push_back(predict_command(item_on_bus));
            req_wait = $urandom_range(req_gap_max, 0);
         end
         if (!req_tvalid || req_tready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               item_on_bus = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_DATA_W'(item_on_bus.temp);
               req_tuser  <= item_on_bus.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check every result transaction against the oldest prediction,
   // then drop tready for a random number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_cmd = rsp_tdata[RESULT_W-1:0];
            results_seen++;
            if (predicted_commands.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want_cmd = predicted_commands.pop_front();
               check_field("drive_milliwatts", want_cmd.drive, seen_cmd.drive);
               check_field("clamp_code", want_cmd.code, seen_cmd.code);
               check_field("temp_error", want_cmd.err, seen_cmd.err);
               check_field("window_sum", want_cmd.sum, seen_cmd.sum);
               check_field("tdata padding", 0, rsp_tdata[RSP_DATA_W-1:RESULT_W]);
            end
            rsp_wait = $urandom_range(rsp_gap_max, 0);
            // once: hold off long enough for the result queue to fill and
            // push back on the request side while the driver keeps offering
            if (results_seen == STALL_AT)
               rsp_wait = STALL_CYCLES;
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Write one register and mirror it into the shadow copy; the controller
   // is idle whenever this runs.
   task automatic write_register(logic [CSR_ADDR_W-1:0] index, int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= CSR_DATA_W'(value);
      case (index)
         CSR_TARGET_TEMP: cfg_target  = TEMP_W'(CSR_DATA_W'(value));
         CSR_KP:          cfg_kp      = GAIN_W'(value);
         CSR_KI:          cfg_ki      = GAIN_W'(value);
         CSR_KD:          cfg_kd      = GAIN_W'(value);
         CSR_MAX_MW:      cfg_max_mw  = MW_W'(value);
         CSR_INIT_MW:     cfg_init_mw = MW_W'(value);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all(int unsigned target, int unsigned kp, int unsigned ki,
                            int unsigned kd, int unsigned max_mw, int unsigned init_mw);
      write_register(CSR_TARGET_TEMP, target);
      write_register(CSR_KP, kp);
      write_register(CSR_KI, ki);
      write_register(CSR_KD, kd);
      write_register(CSR_MAX_MW, max_mw);
      write_register(CSR_INIT_MW, init_mw);
   endtask

   // Set the idling for the next phase away from the clock edge.
   task automatic start_phase(int req_max, int rsp_max);
      @(negedge clock);
      req_gap_max = req_max;
      rsp_gap_max = rsp_max;
   endtask

   function automatic void queue_sample(logic op, int unsigned temp);
      sample_item_type item;
      item.op   = op;
      item.temp = TEMP_W'(temp);
      pending_samples.push_back(item);
   endfunction

   // Wait until every queued sample is accepted and every command is back,
   // then let the pipeline settle.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || predicted_commands.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Mostly modest gains so the drive lands inside the limits, with zero,
   // full-scale and wide random gains mixed in.
   function automatic int unsigned pick_gain();
      case ($urandom_range(5, 0))
         0:       return 0;
         1:       return 65535;
         2:       return $urandom_range(65535, 0);
         default: return $urandom_range(300, 0);
      endcase
   endfunction

   function automatic int unsigned pick_limit(int unsigned lo);
      case ($urandom_range(3, 0))
         0:       return lo;
         1:       return DRIVE_CEIL;
         default: return $urandom_range(DRIVE_CEIL, lo);
      endcase
   endfunction

   // Temperatures: edges of the range, the whole range, and a band around
   // the target where the loop actually regulates.
   function automatic int unsigned pick_temp();
      int t;
      case ($urandom_range(9, 0))
         0:          return 0;
         1:          return (1 << TEMP_W) - 1;
         2, 3, 4, 5: return $urandom_range((1 << TEMP_W) - 1, 0);
         default: begin
            t = int'(cfg_target) + int'($urandom_range(40, 0)) - 20;
            if (t < 0) t = 0;
            if (t > (1 << TEMP_W) - 1) t = (1 << TEMP_W) - 1;
            return t;
         end
      endcase
   endfunction

   function automatic int unsigned pick_target();
      case ($urandom_range(4, 0))
         0:       return 0;
         1:       return (1 << TEMP_W) - 1;
         // throw in junk above bit 9 to check the register masks it
         2:       return $urandom_range((1 << CSR_DATA_W) - 1, 0);
         default: return $urandom_range((1 << TEMP_W) - 1, 0);
      endcase
   endfunction

   initial begin
      int gap_choice[3];
      gap_choice = '{0, 3, 18};
      foreach (err_ring[i]) err_ring[i] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset register values, zero gains, both range extremes,
      // a clear with a nonzero temperature that must be ignored.
      start_phase(0, 0);
      queue_sample(OP_SAMPLE, 0);
      queue_sample(OP_SAMPLE, 1023);
      queue_sample(OP_SAMPLE, 200);
      queue_sample(OP_SAMPLE, 201);
      queue_sample(OP_CLEAR, 1023);
      queue_sample(OP_SAMPLE, 5);
      wait_idle();

      // Directed: full-scale gains drive into the runaway fallback; the
      // target write carries junk above its width; spare addresses are poked.
      write_all(32'h1FC00 | 1023, 65535, 65535, 65535, DRIVE_CEIL, 0);
      write_register(CSR_SPARE_LO, 0);
      write_register(CSR_SPARE_HI, (1 << CSR_DATA_W) - 1);
      start_phase(0, 0);
      queue_sample(OP_SAMPLE, 0);
      queue_sample(OP_SAMPLE, 1023);
      queue_sample(OP_SAMPLE, 1022);
      queue_sample(OP_CLEAR, 0);
      queue_sample(OP_SAMPLE, 1023);
      wait_idle();

      // Directed: derivative only, minimum power limit: limited to max,
      // negative fallback, drive exactly at the limit and one far under it.
      write_all(0, 0, 0, 200, DRIVE_FLOOR, DRIVE_CEIL);
      start_phase(0, 0);
      queue_sample(OP_SAMPLE, 0);
      queue_sample(OP_SAMPLE, 1023);
      queue_sample(OP_SAMPLE, 0);
      queue_sample(OP_SAMPLE, 500);
      queue_sample(OP_SAMPLE, 501);
      queue_sample(OP_CLEAR, 512);
      wait_idle();

      // Directed: mixed-sign terms around a mid target to exercise truncation toward zero.
      write_all(512, 150, 40, 7, MAX_MW_RESET, INIT_MW_RESET);
      start_phase(0, 0);
      queue_sample(OP_SAMPLE, 512);
      queue_sample(OP_SAMPLE, 600);
      queue_sample(OP_SAMPLE, 400);
      queue_sample(OP_SAMPLE, 700);
      queue_sample(OP_SAMPLE, 300);
      queue_sample(OP_SAMPLE, 512);
      queue_sample(OP_SAMPLE, 1023);
      queue_sample(OP_SAMPLE, 0);
      wait_idle();

      // Random phases: fresh register settings each time and every pairing
      // of idle-free, light and heavy idling on the two sides.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_all(pick_target(), pick_gain(), pick_gain(), pick_gain(),
                   pick_limit(DRIVE_FLOOR), pick_limit(0));
         start_phase(gap_choice[phase % 3], gap_choice[(phase / 3) % 3]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(19, 0) == 0)
               queue_sample(OP_CLEAR, $urandom_range((1 << TEMP_W) - 1, 0));
            else
               queue_sample(OP_SAMPLE, pick_temp());
         end
         wait_idle();
      end

      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
